[design/fnmf_pkg.sv]
// Package for the four-neighbour mean filter: sizes, register codes and the
// structs passed between the configuration, window and result modules.
// No dependencies.
package fnmf_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int DIM_W    = 11;
  localparam int PIX_W    = 8;
  localparam int MEAN_W   = 16;
  localparam int SUM_W    = 10;
  localparam int CNT_W    = 3;
  localparam int NCAND    = 3;
  localparam int SEL_W    = $clog2(NCAND);
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [DIM_W-1:0] ROWS_RST = DIM_W'(10);
  localparam logic [DIM_W-1:0] COLS_RST = DIM_W'(10);
  localparam logic [DIM_W-1:0] DIM_MIN  = DIM_W'(2);

  // Register index, taken from the word address.
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic             restart;
  } cfg_t;

  typedef struct packed {
    logic             pres;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             done;
  } cand_t;

endpackage

[design/fnmf_pix_if.sv]
// Pixel input channel: valid/ready handshake with one 8-bit pixel.
// Depends on fnmf_pkg.
interface fnmf_pix_if;
  logic                      valid;
  logic                      ready;
  logic [fnmf_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

[design/fnmf_res_if.sv]
// Result channel: valid/ready handshake carrying one neighbour mean and its
// position and flags. Depends on fnmf_pkg.
interface fnmf_res_if;
  logic                        valid;
  logic                        ready;
  logic [fnmf_pkg::MEAN_W-1:0] mean_value;
  logic [fnmf_pkg::ROW_W-1:0]  result_row;
  logic [fnmf_pkg::COL_W-1:0]  result_col;
  logic                        last_of_run;
  logic                        frame_done;

  modport source (output valid, output mean_value, output result_row, output result_col,
                  output last_of_run, output frame_done, input ready);
  modport sink   (input valid, input mean_value, input result_row, input result_col,
                  input last_of_run, input frame_done, output ready);
endinterface

[design/fnmf_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module fnmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/fnmf_cfg.sv]
// APB-style register file for the frame size, with range clamping and a
// frame restart pulse on every write. Depends on fnmf_pkg.
module fnmf_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fnmf_pkg::CFG_AW-1:0]   paddr,
  input  logic [fnmf_pkg::CFG_DW-1:0]   pwdata,
  output logic [fnmf_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output fnmf_pkg::cfg_t                cfg
);

  logic [fnmf_pkg::DIM_W-1:0] rows_r;
  logic [fnmf_pkg::DIM_W-1:0] cols_r;
  logic                       wr_en;
  logic                       reg_idx;

  function automatic logic [fnmf_pkg::DIM_W-1:0] clamp_dim(
    input logic [fnmf_pkg::DIM_W-1:0] v,
    input logic [fnmf_pkg::DIM_W-1:0] hi
  );
    logic [fnmf_pkg::DIM_W-1:0] res;
    res = v;
    if (v < fnmf_pkg::DIM_MIN) begin
      res = fnmf_pkg::DIM_MIN;
    end else if (v > hi) begin
      res = hi;
    end
    return res;
  endfunction

  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= fnmf_pkg::ROWS_RST;
      cols_r <= fnmf_pkg::COLS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        fnmf_pkg::REG_ROWS: rows_r <= pwdata[fnmf_pkg::DIM_W-1:0];
        fnmf_pkg::REG_COLS: cols_r <= pwdata[fnmf_pkg::DIM_W-1:0];
        default:            rows_r <= rows_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      fnmf_pkg::REG_ROWS: prdata = fnmf_pkg::CFG_DW'(rows_r);
      fnmf_pkg::REG_COLS: prdata = fnmf_pkg::CFG_DW'(cols_r);
      default:            prdata = '0;
    endcase
  end

  assign cfg.rows    = clamp_dim(rows_r, fnmf_pkg::DIM_W'(fnmf_pkg::MAX_ROWS));
  assign cfg.cols    = clamp_dim(cols_r, fnmf_pkg::DIM_W'(fnmf_pkg::MAX_COLS));
  assign cfg.restart = wr_en;

endmodule

[design/fnmf_win.sv]
// Window logic: raster position, the two line stores, the left-pixel taps
// and the neighbour sums for up to three positions released by one pixel.
// Depends on fnmf_pkg, fnmf_pix_if and fnmf_ram.
module fnmf_win (
  input  logic                              clk,
  input  logic                              rst_n,
  fnmf_pix_if.sink                          in_ch,
  input  fnmf_pkg::cfg_t                    cfg,
  input  logic                              pend_busy,
  output logic                              cand_vld,
  output fnmf_pkg::cand_t [fnmf_pkg::NCAND-1:0] cand
);

  typedef struct packed {
    logic [fnmf_pkg::PIX_W-1:0] pix;
    logic [fnmf_pkg::ROW_W-1:0] row;
    logic [fnmf_pkg::COL_W-1:0] col;
    logic                       r_ge1;
    logic                       r_ge2;
    logic                       c_gt0;
    logic                       c_ge2;
    logic                       c_last;
    logic                       r_last;
    logic [fnmf_pkg::PIX_W-1:0] left;
    logic [fnmf_pkg::PIX_W-1:0] sleft;
  } stage_t;

  logic [fnmf_pkg::ROW_W-1:0] row_r;
  logic [fnmf_pkg::COL_W-1:0] col_r;
  logic [fnmf_pkg::PIX_W-1:0] left_r;
  logic [fnmf_pkg::PIX_W-1:0] sleft_r;
  logic                       rv_r;
  stage_t                     st_r;
  logic [fnmf_pkg::PIX_W-1:0] nc_r;
  logic [fnmf_pkg::PIX_W-1:0] pnc_r;

  logic                       accept;
  logic                       c_last;
  logic                       r_last;
  logic [fnmf_pkg::COL_W-1:0] ahead_addr;
  logic [fnmf_pkg::PIX_W-1:0] rd_old;
  logic [fnmf_pkg::PIX_W-1:0] rd_new;

  // One pixel is in the window stage at a time; the result queue must be drained.
  assign in_ch.ready = !rv_r && !pend_busy;
  assign accept      = in_ch.valid && in_ch.ready;

  assign c_last = (fnmf_pkg::DIM_W'(col_r) + fnmf_pkg::DIM_W'(1)) == cfg.cols;
  assign r_last = (fnmf_pkg::DIM_W'(row_r) + fnmf_pkg::DIM_W'(1)) == cfg.rows;

  // The newer store is read one column ahead. At the row end it fetches
  // column 0, which the next row needs as its centre-column value.
  assign ahead_addr = c_last ? '0 : col_r + fnmf_pkg::COL_W'(1);

  fnmf_ram #(.WIDTH(fnmf_pkg::PIX_W), .DEPTH(fnmf_pkg::MAX_COLS)) u_older (
    .clk   (clk),
    .we    (rv_r),
    .waddr (st_r.col),
    .wdata (nc_r),
    .re    (accept),
    .raddr (col_r),
    .rdata (rd_old)
  );

  fnmf_ram #(.WIDTH(fnmf_pkg::PIX_W), .DEPTH(fnmf_pkg::MAX_COLS)) u_newer (
    .clk   (clk),
    .we    (accept),
    .waddr (col_r),
    .wdata (in_ch.pixel_value),
    .re    (accept),
    .raddr (ahead_addr),
    .rdata (rd_new)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      col_r   <= '0;
      left_r  <= '0;
      sleft_r <= '0;
      rv_r    <= 1'b0;
    end else if (cfg.restart) begin
      row_r   <= '0;
      col_r   <= '0;
      left_r  <= '0;
      sleft_r <= '0;
      rv_r    <= 1'b0;
    end else begin
      rv_r <= accept;
      if (accept) begin
        if (c_last) begin
          col_r   <= '0;
          row_r   <= r_last ? '0 : row_r + fnmf_pkg::ROW_W'(1);
          left_r  <= '0;
          sleft_r <= '0;
        end else begin
          col_r   <= col_r + fnmf_pkg::COL_W'(1);
          left_r  <= in_ch.pixel_value;
          sleft_r <= left_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_r.pix    <= in_ch.pixel_value;
      st_r.row    <= row_r;
      st_r.col    <= col_r;
      st_r.r_ge1  <= row_r != '0;
      st_r.r_ge2  <= row_r > fnmf_pkg::ROW_W'(1);
      st_r.c_gt0  <= col_r != '0;
      st_r.c_ge2  <= col_r > fnmf_pkg::COL_W'(1);
      st_r.c_last <= c_last;
      st_r.r_last <= r_last;
      st_r.left   <= left_r;
      st_r.sleft  <= sleft_r;
    end
    if (rv_r) begin
      nc_r  <= rd_new;
      pnc_r <= nc_r;
    end
  end

  // nc_r is the row above at this column, pnc_r the row above one column left.
  always_comb begin
    cand[0].pres = st_r.r_ge1;
    cand[0].sum  = fnmf_pkg::SUM_W'(st_r.pix)
                 + (st_r.r_ge2   ? fnmf_pkg::SUM_W'(rd_old) : '0)
                 + (st_r.c_gt0   ? fnmf_pkg::SUM_W'(pnc_r)  : '0)
                 + (!st_r.c_last ? fnmf_pkg::SUM_W'(rd_new) : '0);
    cand[0].cnt  = fnmf_pkg::CNT_W'(1)
                 + fnmf_pkg::CNT_W'(st_r.r_ge2)
                 + fnmf_pkg::CNT_W'(st_r.c_gt0)
                 + fnmf_pkg::CNT_W'(!st_r.c_last);
    cand[0].row  = st_r.row - fnmf_pkg::ROW_W'(1);
    cand[0].col  = st_r.col;
    cand[0].done = 1'b0;

    cand[1].pres = st_r.r_last && st_r.c_gt0;
    cand[1].sum  = fnmf_pkg::SUM_W'(pnc_r) + fnmf_pkg::SUM_W'(st_r.pix)
                 + (st_r.c_ge2 ? fnmf_pkg::SUM_W'(st_r.sleft) : '0);
    cand[1].cnt  = fnmf_pkg::CNT_W'(2) + fnmf_pkg::CNT_W'(st_r.c_ge2);
    cand[1].row  = st_r.row;
    cand[1].col  = st_r.col - fnmf_pkg::COL_W'(1);
    cand[1].done = 1'b0;

    cand[2].pres = st_r.r_last && st_r.c_last;
    cand[2].sum  = fnmf_pkg::SUM_W'(nc_r) + fnmf_pkg::SUM_W'(st_r.left);
    cand[2].cnt  = fnmf_pkg::CNT_W'(2);
    cand[2].row  = st_r.row;
    cand[2].col  = st_r.col;
    cand[2].done = 1'b1;
  end

  assign cand_vld = rv_r;

endmodule

[design/fnmf_out.sv]
// Result queue and output register: holds the released positions of one
// pixel, divides each sum by its count and sends them one per transfer.
// Depends on fnmf_pkg and fnmf_res_if.
module fnmf_out (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cand_vld,
  input  fnmf_pkg::cand_t [fnmf_pkg::NCAND-1:0] cand,
  output logic                                  pend_busy,
  fnmf_res_if.source                            out_ch
);

  localparam int RECIP_SHIFT = 20;
  localparam int X_W         = fnmf_pkg::SUM_W + 8;
  localparam int PROD_W      = X_W + RECIP_SHIFT;
  // ceil(2^20 / 3): exact floor division by three for operands below 2^19.
  localparam logic [RECIP_SHIFT-1:0] RECIP3 = RECIP_SHIFT'(349526);
  localparam logic [fnmf_pkg::CNT_W-1:0] CNT_TWO   = fnmf_pkg::CNT_W'(2);
  localparam logic [fnmf_pkg::CNT_W-1:0] CNT_THREE = fnmf_pkg::CNT_W'(3);
  localparam logic [fnmf_pkg::CNT_W-1:0] CNT_FOUR  = fnmf_pkg::CNT_W'(4);

  typedef struct packed {
    logic [fnmf_pkg::MEAN_W-1:0] mean;
    logic [fnmf_pkg::ROW_W-1:0]  row;
    logic [fnmf_pkg::COL_W-1:0]  col;
    logic                        last;
    logic                        done;
  } res_t;

  fnmf_pkg::cand_t [fnmf_pkg::NCAND-1:0] pend_r;
  res_t                                  res_r;
  logic                                  out_valid_r;

  logic [fnmf_pkg::NCAND-1:0] pres;
  logic [fnmf_pkg::SEL_W-1:0] sel;
  logic                       found;
  logic                       out_free;
  logic                       emit;
  fnmf_pkg::cand_t            pick;

  function automatic logic [fnmf_pkg::MEAN_W-1:0] mean_of(
    input logic [fnmf_pkg::SUM_W-1:0] s,
    input logic [fnmf_pkg::CNT_W-1:0] n
  );
    logic [X_W-1:0]    x;
    logic [PROD_W-1:0] prod;
    logic [fnmf_pkg::MEAN_W-1:0] res;
    x    = {s, 8'h00};
    prod = PROD_W'(x) * PROD_W'(RECIP3);
    case (n)
      CNT_TWO:   res = x[fnmf_pkg::MEAN_W:1];
      CNT_THREE: res = prod[fnmf_pkg::MEAN_W+RECIP_SHIFT-1:RECIP_SHIFT];
      CNT_FOUR:  res = x[fnmf_pkg::MEAN_W+1:2];
      default:   res = '0;
    endcase
    return res;
  endfunction

  always_comb begin
    for (int i = 0; i < fnmf_pkg::NCAND; i++) begin
      pres[i] = pend_r[i].pres;
    end
  end

  // Positions leave in the order they were released: lowest index first.
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int i = 0; i < fnmf_pkg::NCAND; i++) begin
      if (!found && pres[i]) begin
        sel   = fnmf_pkg::SEL_W'(i);
        found = 1'b1;
      end
    end
  end

  assign pick      = pend_r[sel];
  assign pend_busy = |pres;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign emit      = pend_busy && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fnmf_pkg::NCAND; i++) begin
        pend_r[i].pres <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (cand_vld) begin
        pend_r <= cand;
      end else if (emit) begin
        pend_r[sel].pres <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r.mean <= mean_of(pick.sum, pick.cnt);
      res_r.row  <= pick.row;
      res_r.col  <= pick.col;
      res_r.last <= $countones(pres) == 1;
      res_r.done <= pick.done;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.mean_value  = res_r.mean;
  assign out_ch.result_row  = res_r.row;
  assign out_ch.result_col  = res_r.col;
  assign out_ch.last_of_run = res_r.last;
  assign out_ch.frame_done  = res_r.done;

endmodule

[design/four_neighbour_mean_filter_top.sv]
// Four-neighbour mean filter. Pixels enter in raster order on in_ch; each
// transfer may release up to three results on out_ch, each the mean of the
// up, down, left and right neighbours inside the frame, as unsigned 8.8
// fixed point, with its row, column, last_of_run and frame_done flags.
// Row r releases the positions of row r-1; the last row also releases the
// position one to the left, and the frame's final pixel releases itself.
// An accepted pixel releases n results (0 to 3): line store reads first,
// then one result per cycle into the output register while out_ch is not
// stalled, passing the window stage and the result queue on the way. Due to
// the single read ports and the one-deep queue, in_ch takes no new pixel
// until the queue drains. Frame size is set through the APB port (rows at 0x0,
// columns at 0x4, each 2..1024); any write restarts the frame at (0,0).
// Reset clears the position and puts the frame size at 10 x 10; the line
// stores need no clearing. A stall on out_ch holds the result register and
// the queue, and in_ch stays not ready until the queue has drained.
// Depends on fnmf_pkg, fnmf_pix_if, fnmf_res_if, fnmf_cfg, fnmf_win, fnmf_out.
module four_neighbour_mean_filter_top (
  input  logic                        clk,
  input  logic                        rst_n,
  fnmf_pix_if.sink                    in_ch,
  fnmf_res_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fnmf_pkg::CFG_AW-1:0] paddr,
  input  logic [fnmf_pkg::CFG_DW-1:0] pwdata,
  output logic [fnmf_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  fnmf_pkg::cfg_t                        cfg;
  logic                                  pend_busy;
  logic                                  cand_vld;
  fnmf_pkg::cand_t [fnmf_pkg::NCAND-1:0] cand;

  fnmf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fnmf_win u_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .pend_busy (pend_busy),
    .cand_vld  (cand_vld),
    .cand      (cand)
  );

  fnmf_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .cand_vld  (cand_vld),
    .cand      (cand),
    .pend_busy (pend_busy),
    .out_ch    (out_ch)
  );

  // A new set of positions must never overwrite results still queued.
  a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cand_vld |-> !pend_busy)
    else $error("result queue loaded while not empty");

  // The window stage holds one pixel, so no transfer follows right behind.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("pixel accepted while the window stage was busy");

  // The final position of the frame is always the last result of its pixel.
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frame_done) |-> out_ch.last_of_run)
    else $error("frame_done without last_of_run");

  // While results are still queued the input stays closed.
  a_busy_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    pend_busy |-> !in_ch.ready)
    else $error("input ready while results are queued");

endmodule

[verif/tb_four_neighbour_mean_filter_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for four_neighbour_mean_filter_top: streams frames of pixels,
// predicts every neighbour mean in a scoreboard class and checks each result transfer.
// Depends on fnmf_pkg, fnmf_pix_if, fnmf_res_if and the design under test.
module tb_four_neighbour_mean_filter_top;

  localparam int HALF_PERIOD   = 5;
  localparam int RANDOM_ITEMS  = 325;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int TIMEOUT_NS    = 2_000_000;

  typedef struct packed {
    logic [fnmf_pkg::MEAN_W-1:0] mean;
    logic [fnmf_pkg::ROW_W-1:0]  row;
    logic [fnmf_pkg::COL_W-1:0]  col;
    logic                        last;
    logic                        done;
  } mean_rec_t;

  class mean_tracker;
    int unsigned rows_n, cols_n, row_pos, col_pos;
    logic [fnmf_pkg::PIX_W-1:0] older_line [fnmf_pkg::MAX_COLS];
    logic [fnmf_pkg::PIX_W-1:0] newer_line [fnmf_pkg::MAX_COLS];
    logic [fnmf_pkg::PIX_W-1:0] left_px, left2_px;
    mean_rec_t means_due [$];
    int pixels, checked, errors;

    function new();
      rows_n = 32'(fnmf_pkg::ROWS_RST);
      cols_n = 32'(fnmf_pkg::COLS_RST);
      foreach (older_line[i]) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
      restart();
    endfunction

    function void restart();
      row_pos = 0;
      col_pos = 0;
      left_px = '0;
      left2_px = '0;
    endfunction

    function int unsigned limit_dim(logic [fnmf_pkg::DIM_W-1:0] v, int unsigned hi);
      if (v < fnmf_pkg::DIM_MIN) return 32'(fnmf_pkg::DIM_MIN);
      if (32'(v) > hi) return hi;
      return 32'(v);
    endfunction

    // Any register write restarts the frame; the line stores keep their contents.
    function void set_dim(logic which, logic [fnmf_pkg::DIM_W-1:0] value);
      if (which == fnmf_pkg::REG_ROWS) rows_n = limit_dim(value, fnmf_pkg::MAX_ROWS);
      else cols_n = limit_dim(value, fnmf_pkg::MAX_COLS);
      restart();
    endfunction

    function mean_rec_t form_mean(int unsigned sum, int unsigned cnt, int unsigned row,
                                  int unsigned col, logic done);
      mean_rec_t m;
      m.mean = fnmf_pkg::MEAN_W'((sum * 256) / cnt);
      m.row  = fnmf_pkg::ROW_W'(row);
      m.col  = fnmf_pkg::COL_W'(col);
      m.last = 1'b0;
      m.done = done;
      return m;
    endfunction

    function void note_pixel(logic [fnmf_pkg::PIX_W-1:0] px);
      int unsigned r, c, sum, cnt, n;
      logic [fnmf_pkg::PIX_W-1:0] up_px;
      mean_rec_t found [3];
      pixels++;
      r = row_pos;
      c = col_pos;
      n = 0;
      if (r >= rows_n || c >= cols_n) begin
        r = 0;
        c = 0;
      end
      up_px = older_line[c];
      // The incoming pixel is the lower neighbour of the position one row up.
      if (r >= 1) begin
        sum = 32'(px);
        cnt = 1;
        if (r >= 2) begin
          sum += 32'(up_px);
          cnt++;
        end
        if (c > 0) begin
          sum += 32'(older_line[c-1]);
          cnt++;
        end
        if (c + 1 < cols_n) begin
          sum += 32'(newer_line[c+1]);
          cnt++;
        end
        found[n] = form_mean(sum, cnt, r - 1, c, 1'b0);
        n++;
      end
      older_line[c] = newer_line[c];
      newer_line[c] = px;
      // In the last row the left position is complete, and the final one closes the frame.
      if (r + 1 == rows_n) begin
        if (c >= 1) begin
          sum = 32'(older_line[c-1]) + 32'(px);
          cnt = 2;
          if (c >= 2) begin
            sum += 32'(left2_px);
            cnt++;
          end
          found[n] = form_mean(sum, cnt, r, c - 1, 1'b0);
          n++;
        end
        if (c + 1 == cols_n) begin
          found[n] = form_mean(32'(older_line[c]) + 32'(left_px), 2, r, c, 1'b1);
          n++;
        end
      end
      left2_px = left_px;
      left_px = px;
      c++;
      if (c >= cols_n) begin
        c = 0;
        r++;
        if (r >= rows_n) r = 0;
        left_px = '0;
        left2_px = '0;
      end
      row_pos = r;
      col_pos = c;
      for (int k = 0; k < n; k++) begin
        found[k].last = (k == n - 1);
        means_due.push_back(found[k]);
      end
    endfunction

    function void check_mean(logic [fnmf_pkg::MEAN_W-1:0] mean,
                             logic [fnmf_pkg::ROW_W-1:0] row,
                             logic [fnmf_pkg::COL_W-1:0] col, logic last, logic done);
      mean_rec_t got, want;
      got.mean = mean;
      got.row  = row;
      got.col  = col;
      got.last = last;
      got.done = done;
      if (means_due.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: mean %h row %0d col %0d last %b done %b",
                 $time, mean, row, col, last, done);
        return;
      end
      want = means_due.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        $display("%0t: mismatch: expected mean %h row %0d col %0d last %b done %b,",
                 $time, want.mean, want.row, want.col, want.last, want.done,
                 " got mean %h row %0d col %0d last %b done %b",
                 got.mean, got.row, got.col, got.last, got.done);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [fnmf_pkg::CFG_AW-1:0] paddr;
  logic [fnmf_pkg::CFG_DW-1:0] pwdata, prdata;

  fnmf_pix_if pix_if ();
  fnmf_res_if res_if ();

  mean_tracker tracker = new();

  bit quiet = 1'b0;
  bit hold_request = 1'b0;
  int held_cycles = 0;
  int send_calm = 0;
  int settings = 0;

  four_neighbour_mean_filter_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (pix_if),
    .out_ch  (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic logic [fnmf_pkg::PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return fnmf_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Called at a clock edge; valid is left high after the transfer so that a
  // following pixel is offered without a gap in valid.
  task automatic send_pixel(input logic [fnmf_pkg::PIX_W-1:0] px);
    int gap;
    gap = 0;
    if (send_calm > 0) begin
      send_calm--;
    end else if (!quiet) begin
      case ($urandom_range(0, 7))
        0: gap = $urandom_range(1, 6);
        1: send_calm = $urandom_range(15, 60);
        default: ;
      endcase
    end
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel_value <= px;
    do @(posedge clk); while (!pix_if.ready);
    tracker.note_pixel(px);
  endtask

  // Drops valid, waits for every outstanding mean, then lets the pipeline settle
  // in case the last pixels released nothing.
  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    while (tracker.means_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic which, input logic [fnmf_pkg::DIM_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= {(fnmf_pkg::CFG_DW - fnmf_pkg::DIM_W)'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    tracker.set_dim(which, value);
  endtask

  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready)
      tracker.check_mean(res_if.mean_value, res_if.result_row, res_if.result_col,
                         res_if.last_of_run, res_if.frame_done);
  end

  initial begin : result_sink
    int stall_left, calm_left;
    stall_left = 0;
    calm_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
        held_cycles = LONG_HOLD;
      end
      if (quiet) stall_left = 0;
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else if (!quiet) begin
          case ($urandom_range(0, 9))
            0, 1: stall_left = $urandom_range(1, 6);
            2: calm_left = $urandom_range(20, 80);
            default: ;
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    logic [fnmf_pkg::DIM_W-1:0] rows_raw, cols_raw;
    int n, frame_px, random_px, which;
    bit hold_done;
    hold_done = 1'b0;
    random_px = 0;
    rst_n <= 1'b0;
    pix_if.valid <= 1'b0;
    pix_if.pixel_value <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset frame size: first row and the start of the second.
    for (int k = 0; k < 11; k++) send_pixel((k % 2) ? 8'h00 : 8'hFF);
    wait_drained();
    // Sizes below the minimum act as 2 x 2; one full frame of full-scale pixels, then a wrap.
    cfg_write(fnmf_pkg::REG_ROWS, 11'd1);
    cfg_write(fnmf_pkg::REG_COLS, 11'd0);
    repeat (5) send_pixel(8'hFF);
    wait_drained();
    // 3 x 3 brings in every border case, including the three-term last-row mean.
    cfg_write(fnmf_pkg::REG_ROWS, 11'd3);
    cfg_write(fnmf_pkg::REG_COLS, 11'd3);
    repeat (9) send_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00);
    settings = 3;

    while (random_px < RANDOM_ITEMS) begin
      wait_drained();
      case ($urandom_range(0, 9))
        0: begin
          rows_raw = fnmf_pkg::DIM_W'($urandom_range(0, 1));
          cols_raw = fnmf_pkg::DIM_W'($urandom_range(2, 9));
        end
        1: begin
          rows_raw = fnmf_pkg::DIM_W'($urandom_range(2, 5));
          cols_raw = fnmf_pkg::DIM_W'($urandom_range(0, 1));
        end
        2: begin
          rows_raw = fnmf_pkg::DIM_W'($urandom_range(1024, 2047));
          cols_raw = fnmf_pkg::DIM_W'($urandom_range(2, 3));
        end
        3: begin
          rows_raw = fnmf_pkg::DIM_W'($urandom_range(2, 3));
          cols_raw = fnmf_pkg::DIM_W'($urandom_range(1024, 2047));
        end
        4: begin
          rows_raw = 11'd2;
          cols_raw = fnmf_pkg::DIM_W'($urandom_range(16, 48));
        end
        default: begin
          rows_raw = fnmf_pkg::DIM_W'($urandom_range(2, 7));
          cols_raw = fnmf_pkg::DIM_W'($urandom_range(2, 10));
        end
      endcase
      which = $urandom_range(0, 2);
      if (which != 1) cfg_write(fnmf_pkg::REG_ROWS, rows_raw);
      if (which != 0) cfg_write(fnmf_pkg::REG_COLS, cols_raw);
      settings++;
      frame_px = tracker.rows_n * tracker.cols_n;
      if (frame_px <= 40) n = frame_px * $urandom_range(1, 2) + $urandom_range(0, tracker.cols_n);
      else if (frame_px <= 120) n = frame_px + $urandom_range(0, 3);
      else n = $urandom_range(12, 40);
      // Stall the result side for a long stretch once, while pixels keep coming.
      if (!hold_done && frame_px <= 40) begin
        hold_request = 1'b1;
        hold_done = 1'b1;
      end
      repeat (n) send_pixel(rand_pixel());
      random_px += n;
    end

    // Closing stretch runs at full rate on both sides.
    wait_drained();
    quiet = 1'b1;
    cfg_write(fnmf_pkg::REG_ROWS, 11'd4);
    cfg_write(fnmf_pkg::REG_COLS, 11'd5);
    settings++;
    repeat (45) send_pixel(rand_pixel());
    wait_drained();

    $display("Covered %0d pixels under %0d frame settings; %0d means checked.",
             tracker.pixels, settings, tracker.checked);
    $display("Output side held off for %0d cycles once; %0d errors.",
             held_cycles, tracker.errors);
    if (tracker.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timed out with %0d means outstanding.", tracker.means_due.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

[four_neighbour_mean_filter_top.f]
design/fnmf_pkg.sv
design/fnmf_pix_if.sv
design/fnmf_res_if.sv
design/fnmf_ram.sv
design/fnmf_cfg.sv
design/fnmf_win.sv
design/fnmf_out.sv
design/four_neighbour_mean_filter_top.sv
verif/tb_four_neighbour_mean_filter_top.sv
